FILE: sv/vaa_pkg.sv
// Shared constants, types and the arctangent table for the vector angle block.
// No dependencies; every other source file uses this package.
package vaa_pkg;

    localparam int INPUT_BITS_DEF = 16;
    localparam int ANGLE_BITS_DEF = 16;
    localparam int ITERATIONS_DEF = 16;

    // Fraction bits added below the input, and the accumulator's turn resolution.
    localparam int GUARD_BITS = 24;
    localparam int TURN_BITS  = 32;
    localparam int TABLE_LEN  = 32;

    // atan(2^-i) / (2*pi) * 2^32, rounded to nearest
    localparam logic [TURN_BITS-1:0] ATAN_TABLE [TABLE_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    // Control that travels alongside each word in the pipeline
    typedef struct packed {
        logic valid;
        logic special;   // x was zero: bypass the rotation result
        logic ypos;      // y was strictly positive
    } t_ctrl;

    function automatic logic [TURN_BITS-1:0] atan_entry(input int step);
        logic [TURN_BITS-1:0] v;
        v = ATAN_TABLE[step];
        return v;
    endfunction

endpackage

FILE: sv/vaa_stage.sv
// One registered CORDIC vectoring micro-rotation of the angle pipeline.
// Depends on vaa_pkg for the control struct and the arctangent table.
module vaa_stage #(
    parameter int W    = 43,
    parameter int STEP = 0
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  vaa_pkg::t_ctrl                 i_ctrl,
    input  logic signed [W-1:0]            i_x,
    input  logic signed [W-1:0]            i_y,
    input  logic [vaa_pkg::TURN_BITS-1:0]  i_z,
    output vaa_pkg::t_ctrl                 o_ctrl,
    output logic signed [W-1:0]            o_x,
    output logic signed [W-1:0]            o_y,
    output logic [vaa_pkg::TURN_BITS-1:0]  o_z
);
    import vaa_pkg::*;

    localparam logic [TURN_BITS-1:0] ANGLE = atan_entry(STEP);

    t_ctrl                 r_ctrl;
    logic signed [W-1:0]   r_x, r_y;
    logic [TURN_BITS-1:0]  r_z;
    logic signed [W-1:0]   n_x, n_y;
    logic [TURN_BITS-1:0]  n_z;
    logic signed [W-1:0]   xs, ys;

    always_comb begin
        // arithmetic shift floors, as the rotation needs
        xs = i_x >>> STEP;
        ys = i_y >>> STEP;
        if (!i_y[W-1]) begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + ANGLE;
        end else begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - ANGLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else begin
            r_ctrl <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_ctrl = r_ctrl;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;

endmodule

FILE: sv/vector_angle_atan2.sv
// Top level of the vector angle block: input fold, CORDIC pipeline, rounding.
// Depends on vaa_pkg and vaa_stage.

// Polar angle of a signed vector as a binary angle (2^ANGLE_BITS units per turn).
// One vector is taken every clock; busy is high only while reset is applied.
// Each result appears on o_angle with o_strobe high for one cycle, after the
// vector passes a register that folds it into the right half-plane, one
// pipeline stage per CORDIC micro-rotation, and a register that rounds and
// maps the angle. The receiver cannot stall the pipeline.
// i_cfg_data[0] set by i_cfg_we picks the signed range (-half, +half] instead
// of [0, full); change it only while no vectors are in flight.
module vector_angle_atan2 #(
    parameter int INPUT_BITS = vaa_pkg::INPUT_BITS_DEF,
    parameter int ANGLE_BITS = vaa_pkg::ANGLE_BITS_DEF,
    parameter int ITERATIONS = vaa_pkg::ITERATIONS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [INPUT_BITS-1:0]  i_vec_x,
    input  logic signed [INPUT_BITS-1:0]  i_vec_y,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_data,
    output logic                          o_strobe,
    output logic signed [ANGLE_BITS:0]    o_angle
);
    import vaa_pkg::*;

    // Room for negation and CORDIC gain on top of the guard bits
    localparam int W  = INPUT_BITS + GUARD_BITS + 3;
    localparam int SH = TURN_BITS - ANGLE_BITS;
    localparam logic [TURN_BITS-1:0]  ROUND   = (TURN_BITS'(1) << SH) >> 1;
    localparam logic [TURN_BITS-1:0]  Z_HALF  = TURN_BITS'(1) << (TURN_BITS - 1);
    localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
    localparam logic [ANGLE_BITS-1:0] THREE_Q = ANGLE_BITS'(3) << (ANGLE_BITS - 2);
    localparam logic [ANGLE_BITS-1:0] HALF    = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

    logic                   r_busy;
    logic                   r_signed;
    t_ctrl                  r_ctrl0;
    logic signed [W-1:0]    r_x0, r_y0;
    logic [TURN_BITS-1:0]   r_z0;
    logic                   r_strobe;
    logic [ANGLE_BITS:0]    r_angle;

    t_ctrl                  n_ctrl0;
    logic signed [W-1:0]    n_x0, n_y0;
    logic [TURN_BITS-1:0]   n_z0;
    logic [ANGLE_BITS:0]    n_angle;

    logic signed [W-1:0]    ext_x, ext_y;
    logic                   x_neg;
    logic [TURN_BITS-1:0]   z_round;
    logic [ANGLE_BITS-1:0]  a_raw;
    logic [ANGLE_BITS-1:0]  a_sel;

    t_ctrl                  s_ctrl [ITERATIONS+1];
    logic signed [W-1:0]    s_x    [ITERATIONS+1];
    logic signed [W-1:0]    s_y    [ITERATIONS+1];
    logic [TURN_BITS-1:0]   s_z    [ITERATIONS+1];

    // Input fold: turn left half-plane vectors by half a turn
    always_comb begin
        ext_x = {{(W-INPUT_BITS){i_vec_x[INPUT_BITS-1]}}, i_vec_x};
        ext_y = {{(W-INPUT_BITS){i_vec_y[INPUT_BITS-1]}}, i_vec_y};
        x_neg = i_vec_x[INPUT_BITS-1];
        if (x_neg) begin
            n_x0 = (-ext_x) <<< GUARD_BITS;
            n_y0 = (-ext_y) <<< GUARD_BITS;
            n_z0 = Z_HALF;
        end else begin
            n_x0 = ext_x <<< GUARD_BITS;
            n_y0 = ext_y <<< GUARD_BITS;
            n_z0 = '0;
        end
        n_ctrl0.valid   = start && !r_busy;
        n_ctrl0.special = (i_vec_x == '0);
        n_ctrl0.ypos    = !i_vec_y[INPUT_BITS-1] && (i_vec_y != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b1;
            r_signed <= 1'b0;
            r_ctrl0  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_busy   <= 1'b0;
            if (i_cfg_we) begin
                r_signed <= i_cfg_data;
            end
            r_ctrl0  <= n_ctrl0;
            r_strobe <= s_ctrl[ITERATIONS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x0    <= n_x0;
        r_y0    <= n_y0;
        r_z0    <= n_z0;
        r_angle <= n_angle;
    end

    assign s_ctrl[0] = r_ctrl0;
    assign s_x[0]    = r_x0;
    assign s_y[0]    = r_y0;
    assign s_z[0]    = r_z0;

    for (genvar g = 0; g < ITERATIONS; g++) begin : g_rot
        vaa_stage #(
            .W    (W),
            .STEP (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (s_ctrl[g]),
            .i_x     (s_x[g]),
            .i_y     (s_y[g]),
            .i_z     (s_z[g]),
            .o_ctrl  (s_ctrl[g+1]),
            .o_x     (s_x[g+1]),
            .o_y     (s_y[g+1]),
            .o_z     (s_z[g+1])
        );
    end

    // Round half-up to the output resolution; a carry to a full turn wraps to zero
    always_comb begin
        z_round = s_z[ITERATIONS] + ROUND;
        a_raw   = z_round[TURN_BITS-1:SH];
        if (s_ctrl[ITERATIONS].special) begin
            a_sel = s_ctrl[ITERATIONS].ypos ? QUARTER : THREE_Q;
        end else begin
            a_sel = a_raw;
        end
        // subtracting a full turn only sets the sign bit
        n_angle = {r_signed && (a_sel > HALF), a_sel};
    end

    assign busy     = r_busy;
    assign o_strobe = r_strobe;
    assign o_angle  = r_angle;

endmodule

FILE: sv/vaa_checker.sv
// Port-level checks on the vector angle block, bound to its top level.
// Depends on vaa_pkg for the default sizes.
module vaa_checker #(
    parameter int INPUT_BITS = vaa_pkg::INPUT_BITS_DEF,
    parameter int ANGLE_BITS = vaa_pkg::ANGLE_BITS_DEF,
    parameter int ITERATIONS = vaa_pkg::ITERATIONS_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic signed [INPUT_BITS-1:0]  i_vec_x,
    input logic signed [INPUT_BITS-1:0]  i_vec_y,
    input logic                          o_strobe,
    input logic signed [ANGLE_BITS:0]    o_angle
);
    localparam int LAT = ITERATIONS + 2;
    localparam logic [ANGLE_BITS:0] QUARTER = (ANGLE_BITS+1)'(1) << (ANGLE_BITS - 2);

    logic take;
    logic take_up;

    assign take    = start && !busy;
    assign take_up = take && (i_vec_x == '0) && !i_vec_y[INPUT_BITS-1] && (i_vec_y != '0);

    // every word taken comes out after the fixed latency
    a_out_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> ##LAT o_strobe)
        else $error("taken word gave no result");

    // no result without a word taken
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(take, LAT))
        else $error("result without a taken word");

    // a vertical upward vector is a quarter turn in either range
    a_quarter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take_up |-> ##LAT (o_angle == QUARTER))
        else $error("vertical vector not a quarter turn");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_strobe && busy))
        else $error("activity straight after reset");

endmodule

bind vector_angle_atan2 vaa_checker #(
    .INPUT_BITS (INPUT_BITS),
    .ANGLE_BITS (ANGLE_BITS),
    .ITERATIONS (ITERATIONS)
) u_vaa_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_vec_x  (i_vec_x),
    .i_vec_y  (i_vec_y),
    .o_strobe (o_strobe),
    .o_angle  (o_angle)
);

FILE: sim/tb.sv
// Self-checking bench for vector_angle_atan2: drives vectors through the start/busy handshake
// and checks every strobed angle against a CORDIC predictor held in the bench.
// Depends on vaa_pkg (for port widths) and the vector_angle_atan2 RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IN_W    = vaa_pkg::INPUT_BITS_DEF;
    localparam int ANG_W   = vaa_pkg::ANGLE_BITS_DEF;
    localparam int ITER    = vaa_pkg::ITERATIONS_DEF;
    localparam int LATENCY = ITER + 2;
    localparam int GUARD   = 24;
    localparam int TURN_W  = 32;
    localparam longint unsigned FULL    = 64'd1 << ANG_W;
    localparam longint unsigned HALF    = 64'd1 << (ANG_W - 1);
    localparam longint unsigned QUARTER = 64'd1 << (ANG_W - 2);
    localparam bit RANGE_UNSIGNED = 1'b0;
    localparam bit RANGE_SIGNED   = 1'b1;
    localparam int PHASES     = 10;
    localparam int PHASE_LEN  = 125;

    // atan(2^-i) in units of 2^-32 turn
    localparam longint ATAN_TURN [16] = '{
        536870912, 316933406, 167458907, 85004756,
        42667331,  21354465,  10679838,  5340245,
        2670163,   1335087,   667544,    333772,
        166886,    83443,     41722,     20861
    };

    localparam logic signed [IN_W-1:0] CORNER_VALS [6] = '{
        -16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767
    };

    // first twelve in the unsigned range, the rest in the signed range
    localparam logic signed [IN_W-1:0] DIR_X [24] = '{
        0, 0, 0, 32767, -32768, 32767, 32767, -32768, -1, 1, -32768, -1,
        0, 0, 0, -32768, -1, -32768, -32768, 32767, -32768, -5, 1, 32767
    };
    localparam logic signed [IN_W-1:0] DIR_Y [24] = '{
        0, 5, -32768, 0, 0, -1, 32767, -32768, 1, -32768, 32767, 0,
        0, 32767, -1, 0, 0, 1, -1, -32768, -32767, -3, 1, 1
    };

    typedef struct {
        logic signed [IN_W-1:0] x;
        logic signed [IN_W-1:0] y;
        bit                     signed_mode;
        logic signed [ANG_W:0]  angle;
    } t_angle_word;

    class angle_ledger;
        t_angle_word pending[$];
        int unsigned errors;
        int unsigned n_checked;
        int unsigned n_signed;
        int unsigned n_unsigned;

        function automatic logic signed [ANG_W:0] predict_angle(
            logic signed [IN_W-1:0] vx, logic signed [IN_W-1:0] vy, bit signed_mode);
            longint px, py, pz, sx, sy, res;
            longint unsigned turn, a;
            px = vx;
            py = vy;
            pz = 0;
            if (px == 0) begin
                a = (py > 0) ? QUARTER : 3 * QUARTER;
            end else begin
                // fold into the right half-plane and carry half a turn
                if (px < 0) begin
                    px = -px;
                    py = -py;
                    pz = 64'sd1 <<< (TURN_W - 1);
                end
                px = px <<< GUARD;
                py = py <<< GUARD;
                for (int i = 0; i < ITER; i++) begin
                    sx = px >>> i;
                    sy = py >>> i;
                    if (py >= 0) begin
                        px = px + sy;
                        py = py - sx;
                        pz = pz + ATAN_TURN[i];
                    end else begin
                        px = px - sy;
                        py = py + sx;
                        pz = pz - ATAN_TURN[i];
                    end
                end
                turn = longint'(pz) & 64'hFFFF_FFFF;
                turn = (turn + (64'd1 << (TURN_W - ANG_W - 1))) >> (TURN_W - ANG_W);
                a = turn & (FULL - 1);
            end
            res = longint'(a);
            if (signed_mode && a > HALF) begin
                res = res - longint'(FULL);
            end
            return res[ANG_W:0];
        endfunction

        function void note_vector(logic signed [IN_W-1:0] vx, logic signed [IN_W-1:0] vy,
                                  bit signed_mode);
            t_angle_word w;
            w.x = vx;
            w.y = vy;
            w.signed_mode = signed_mode;
            w.angle = predict_angle(vx, vy, signed_mode);
            pending = {pending, w};
            if (signed_mode) n_signed++;
            else n_unsigned++;
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_angle(logic signed [ANG_W:0] got);
            t_angle_word w;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("angle %0d strobed with no vector waiting", got));
            end else begin
                w = pending.pop_front();
                n_checked++;
                if (got !== w.angle) begin
                    report_mismatch($sformatf("x=%0d y=%0d signed=%0b: angle %0d, want %0d",
                                              w.x, w.y, w.signed_mode, got, w.angle));
                end
            end
        endtask

        task check_drained();
            if (pending.size() != 0) begin
                report_mismatch($sformatf("%0d angles never strobed", pending.size()));
            end
        endtask
    endclass

    logic                   i_clk;
    logic                   i_rst_n    = 1'b0;
    logic                   start      = 1'b0;
    logic                   busy;
    logic signed [IN_W-1:0] i_vec_x    = '0;
    logic signed [IN_W-1:0] i_vec_y    = '0;
    logic                   i_cfg_we   = 1'b0;
    logic                   i_cfg_data = 1'b0;
    logic                   o_strobe;
    logic signed [ANG_W:0]  o_angle;

    angle_ledger ledger = new();
    bit          range_mode;
    bit          back_to_back;
    int unsigned n_range_writes;

    vector_angle_atan2 uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_vec_x    (i_vec_x),
        .i_vec_y    (i_vec_y),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_strobe   (o_strobe),
        .o_angle    (o_angle)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1) begin
            ledger.check_angle(o_angle);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (back_to_back || r < 40) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic pick_vector(output logic signed [IN_W-1:0] vx,
                               output logic signed [IN_W-1:0] vy);
        int r;
        r = $urandom_range(0, 99);
        vx = IN_W'($urandom);
        vy = IN_W'($urandom);
        if (r >= 50 && r < 65) begin
            vx = IN_W'(int'($urandom_range(0, 8)) - 4);
            vy = IN_W'(int'($urandom_range(0, 8)) - 4);
        end else if (r >= 65 && r < 75) begin
            vx = '0;
        end else if (r >= 75 && r < 85) begin
            // x axis and diagonals
            case ($urandom_range(0, 2))
                0: vy = '0;
                1: vy = vx;
                default: vy = -vx;
            endcase
        end else if (r >= 85) begin
            vx = CORNER_VALS[$urandom_range(0, 5)];
            vy = CORNER_VALS[$urandom_range(0, 5)];
        end
    endtask

    task automatic send_vector(logic signed [IN_W-1:0] vx, logic signed [IN_W-1:0] vy);
        int gap;
        @(negedge i_clk);
        start   <= 1'b1;
        i_vec_x <= vx;
        i_vec_y <= vy;
        do @(posedge i_clk); while (busy);
        ledger.note_vector(vx, vy, range_mode);
        gap = pick_gap();
        if (gap > 0) begin
            // drop start and put junk on the vector while idle
            @(negedge i_clk);
            start   <= 1'b0;
            i_vec_x <= IN_W'($urandom);
            i_vec_y <= IN_W'($urandom);
            repeat (gap - 1) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (ledger.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic set_range(bit mode);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= mode;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        range_mode = mode;
        n_range_writes++;
    endtask

    initial begin
        logic signed [IN_W-1:0] vx, vy;
        bit first_mode;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_range(RANGE_UNSIGNED);
        for (int i = 0; i < 24; i++) begin
            if (i == 12) begin
                drain();
                set_range(RANGE_SIGNED);
            end
            send_vector(DIR_X[i], DIR_Y[i]);
        end
        drain();

        first_mode = 1'($urandom_range(0, 1));
        for (int p = 0; p < PHASES; p++) begin
            set_range(first_mode ^ p[0]);
            back_to_back = ($urandom_range(0, 3) == 0);
            repeat (PHASE_LEN) begin
                pick_vector(vx, vy);
                send_vector(vx, vy);
            end
            drain();
        end

        ledger.check_drained();
        $display("Checked %0d angles: %0d vectors in unsigned range, %0d in signed range.",
                 ledger.n_checked, ledger.n_unsigned, ledger.n_signed);
        $display("Range register written %0d times; %0d mismatches.",
                 n_range_writes, ledger.errors);
        if (ledger.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timed out with %0d angles outstanding.", ledger.pending.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: filelist.f
sv/vaa_pkg.sv
sv/vaa_stage.sv
sv/vector_angle_atan2.sv
sv/vaa_checker.sv
sim/tb.sv
